[hdl/vcs_pkg.sv]
// ----------------------------------------------------------------------------
// vcs_pkg: shared types and constants for the cosine similarity block
// Widths, the multiplier command beat and its accumulator destinations.
// ----------------------------------------------------------------------------
package vcs_pkg;

  localparam int unsigned ELEM_W    = 16;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned LIMB_W    = 32;
  localparam int unsigned PROD_W    = 2 * LIMB_W;
  localparam int unsigned WIDE_W    = 128;
  localparam int unsigned Q_W       = 15;
  localparam int unsigned COS_W     = 16;
  localparam int unsigned TT_W      = 30;
  localparam int unsigned RHS_SHIFT = 30;

  localparam logic [Q_W-1:0] ONE_Q14 = Q_W'(16384);

  typedef enum logic [1:0] {
    DST_DOT,
    DST_SA,
    DST_SB,
    DST_WIDE
  } vcs_dst_e;

  typedef struct packed {
    logic              valid;
    logic [LIMB_W-1:0] x;
    logic [LIMB_W-1:0] y;
    logic [1:0]        shift;   // limb offset of the product
    logic              neg;     // subtract from a 48-bit accumulator
    logic              clear;   // wide accumulator takes the product alone
    vcs_dst_e          dst;
  } vcs_mul_cmd_t;

endpackage

[hdl/vcs_mac.sv]
// ----------------------------------------------------------------------------
// vcs_mac: shared multiply-accumulate unit
// One 32x32 multiplier with a registered product, then one add into the
// selected accumulator: the three 48-bit sums or the 128-bit work register.
// ----------------------------------------------------------------------------
module vcs_mac (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  vcs_pkg::vcs_mul_cmd_t        cmd_i,
  input  logic                         clr_acc_i,
  output logic [vcs_pkg::ACC_W-1:0]    dot_o,
  output logic [vcs_pkg::ACC_W-1:0]    sa_o,
  output logic [vcs_pkg::ACC_W-1:0]    sb_o,
  output logic [vcs_pkg::WIDE_W-1:0]   wide_o
);
  import vcs_pkg::*;

  localparam int unsigned LIMB_SH = $clog2(LIMB_W);

  logic [PROD_W-1:0] p_q;
  logic              pv_q;
  logic [1:0]        shift_q;
  logic              neg_q;
  logic              clear_q;
  vcs_dst_e          dst_q;

  logic [ACC_W-1:0]  dot_q, dot_d, sa_q, sa_d, sb_q, sb_d;
  logic [WIDE_W-1:0] wide_q, wide_d;
  logic [WIDE_W-1:0] addend;
  logic [ACC_W-1:0]  delta;

  always_comb begin
    addend = {{(WIDE_W-PROD_W){1'b0}}, p_q} << {shift_q, {LIMB_SH{1'b0}}};
    delta  = neg_q ? (ACC_W'(0) - p_q[ACC_W-1:0]) : p_q[ACC_W-1:0];
    dot_d  = dot_q;
    sa_d   = sa_q;
    sb_d   = sb_q;
    wide_d = wide_q;
    if (pv_q) begin
      unique case (dst_q)
        DST_DOT:  dot_d  = dot_q + delta;
        DST_SA:   sa_d   = sa_q + delta;
        DST_SB:   sb_d   = sb_q + delta;
        DST_WIDE: wide_d = clear_q ? addend : (wide_q + addend);
        default:  wide_d = wide_q;
      endcase
    end
    if (clr_acc_i) begin
      dot_d = '0;
      sa_d  = '0;
      sb_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      dot_q <= '0;
      sa_q  <= '0;
      sb_q  <= '0;
    end else begin
      pv_q  <= cmd_i.valid;
      dot_q <= dot_d;
      sa_q  <= sa_d;
      sb_q  <= sb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= cmd_i.x * cmd_i.y;
    shift_q <= cmd_i.shift;
    neg_q   <= cmd_i.neg;
    clear_q <= cmd_i.clear;
    dst_q   <= cmd_i.dst;
    wide_q  <= wide_d;
  end

  assign dot_o  = dot_q;
  assign sa_o   = sa_q;
  assign sb_o   = sb_q;
  assign wide_o = wide_q;

endmodule

[hdl/vector_cosine_similarity_top.sv]
// ----------------------------------------------------------------------------
// vector_cosine_similarity_top: streamed cosine similarity of two vectors
// Accumulates dot product and sums of squares per element pair; on the last
// pair returns the cosine in signed Q1.14 by a bisection search, or 0 with zero_vector_o.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------
//  in      | in_valid_i / in_ready_o   | a_elem_i, b_elem_i, last_i
//  out     | out_valid_o / out_ready_i | cosine_o, zero_vector_o
//
//  An element pair is taken as one beat, then three products go through the
//  one shared 32x32 multiplier before the next pair is taken. After the last pair,
//  a zero vector goes straight to the output; else two 4-product 48x48 multiplies
//  and up to 15 bisection steps follow, each a square and a 3-product multiply.
//  Reset is asynchronous and clears control and the accumulators.
//  A result waiting in the output register stalls only the next last pair.
// ----------------------------------------------------------------------------
module vector_cosine_similarity_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [vcs_pkg::ELEM_W-1:0]   a_elem_i,
  input  logic signed [vcs_pkg::ELEM_W-1:0]   b_elem_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [vcs_pkg::COS_W-1:0]    cosine_o,
  output logic                                zero_vector_o
);
  import vcs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_AA, ST_BB, ST_AB, ST_LWAIT, ST_CHK,
    ST_PMUL, ST_PWAIT, ST_PSAVE, ST_DMUL, ST_DWAIT, ST_DSAVE,
    ST_STOP, ST_STW, ST_STT, ST_SMUL, ST_SWAIT, ST_SCMP, ST_OUT
  } state_e;

  state_e               state_q, state_d;
  logic [ELEM_W-1:0]    a_q, a_d, b_q, b_d;
  logic                 last_q, last_d;
  logic [1:0]           k_q, k_d;
  logic                 neg_q, neg_d;
  logic [ACC_W-1:0]     mag_q, mag_d;
  logic [3*LIMB_W-1:0]  prod_q, prod_d;
  logic [WIDE_W-1:0]    rhs_q, rhs_d;
  logic [Q_W-1:0]       lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [TT_W-1:0]      tt_q, tt_d;
  logic [COS_W-1:0]     res_q, res_d;
  logic                 rzero_q, rzero_d;
  logic                 out_valid_q, out_valid_d;
  logic [COS_W-1:0]     cos_q, cos_d;
  logic                 zero_q, zero_d;

  vcs_mul_cmd_t         cmd;
  logic                 clr_acc;
  logic [ACC_W-1:0]     dot, sa, sb;
  logic [WIDE_W-1:0]    wide;

  logic [ELEM_W:0]      a_mag, b_mag;
  logic [Q_W:0]         mid_sum;
  logic [Q_W:0]         t_val;

  vcs_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .clr_acc_i (clr_acc),
    .dot_o     (dot),
    .sa_o      (sa),
    .sb_o      (sb),
    .wide_o    (wide)
  );

  always_comb begin
    a_mag   = a_q[ELEM_W-1] ? ((ELEM_W+1)'(0) - {1'b1, a_q}) : {1'b0, a_q};
    b_mag   = b_q[ELEM_W-1] ? ((ELEM_W+1)'(0) - {1'b1, b_q}) : {1'b0, b_q};
    mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (Q_W+1)'(1);
    t_val   = {mid_q, 1'b0} - (Q_W+1)'(1);

    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    last_d      = last_q;
    k_d         = k_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    prod_d      = prod_q;
    rhs_d       = rhs_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    tt_d        = tt_q;
    res_d       = res_q;
    rzero_d     = rzero_q;
    cos_d       = cos_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    clr_acc     = 1'b0;
    in_ready_o  = 1'b0;

    cmd       = '0;
    cmd.dst   = DST_WIDE;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          a_d     = a_elem_i;
          b_d     = b_elem_i;
          last_d  = last_i;
          state_d = ST_AA;
        end
      end
      ST_AA: begin
        cmd.valid = 1'b1;
        cmd.x     = LIMB_W'(a_mag);
        cmd.y     = LIMB_W'(a_mag);
        cmd.dst   = DST_SA;
        state_d   = ST_BB;
      end
      ST_BB: begin
        cmd.valid = 1'b1;
        cmd.x     = LIMB_W'(b_mag);
        cmd.y     = LIMB_W'(b_mag);
        cmd.dst   = DST_SB;
        state_d   = ST_AB;
      end
      ST_AB: begin
        cmd.valid = 1'b1;
        cmd.x     = LIMB_W'(a_mag);
        cmd.y     = LIMB_W'(b_mag);
        cmd.neg   = a_q[ELEM_W-1] ^ b_q[ELEM_W-1];
        cmd.dst   = DST_DOT;
        state_d   = last_q ? ST_LWAIT : ST_IDLE;
      end
      ST_LWAIT: state_d = ST_CHK;
      ST_CHK: begin
        k_d = '0;
        if (sa == '0 || sb == '0) begin
          res_d   = '0;
          rzero_d = 1'b1;
          state_d = ST_OUT;
        end else begin
          rzero_d = 1'b0;
          neg_d   = dot[ACC_W-1];
          mag_d   = dot[ACC_W-1] ? (ACC_W'(0) - dot) : dot;
          state_d = ST_PMUL;
        end
      end
      ST_PMUL: begin
        cmd.valid = 1'b1;
        cmd.x     = k_q[0] ? LIMB_W'(sa[ACC_W-1:LIMB_W]) : sa[LIMB_W-1:0];
        cmd.y     = k_q[1] ? LIMB_W'(sb[ACC_W-1:LIMB_W]) : sb[LIMB_W-1:0];
        cmd.shift = {1'b0, k_q[0]} + {1'b0, k_q[1]};
        cmd.clear = (k_q == 2'd0);
        k_d       = k_q + 2'd1;
        if (k_q == 2'd3) state_d = ST_PWAIT;
      end
      ST_PWAIT: state_d = ST_PSAVE;
      ST_PSAVE: begin
        prod_d  = wide[3*LIMB_W-1:0];
        k_d     = '0;
        state_d = ST_DMUL;
      end
      ST_DMUL: begin
        cmd.valid = 1'b1;
        cmd.x     = k_q[0] ? LIMB_W'(mag_q[ACC_W-1:LIMB_W]) : mag_q[LIMB_W-1:0];
        cmd.y     = k_q[1] ? LIMB_W'(mag_q[ACC_W-1:LIMB_W]) : mag_q[LIMB_W-1:0];
        cmd.shift = {1'b0, k_q[0]} + {1'b0, k_q[1]};
        cmd.clear = (k_q == 2'd0);
        k_d       = k_q + 2'd1;
        if (k_q == 2'd3) state_d = ST_DWAIT;
      end
      ST_DWAIT: state_d = ST_DSAVE;
      ST_DSAVE: begin
        rhs_d   = wide << RHS_SHIFT;
        lo_d    = '0;
        hi_d    = ONE_Q14;
        state_d = ST_STOP;
      end
      ST_STOP: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_sum[Q_W:1];
          state_d = ST_STW;
        end else begin
          res_d   = neg_q ? (COS_W'(0) - {1'b0, lo_q}) : {1'b0, lo_q};
          state_d = ST_OUT;
        end
      end
      ST_STW: begin
        // square of 2*mid-1
        cmd.valid = 1'b1;
        cmd.x     = LIMB_W'(t_val);
        cmd.y     = LIMB_W'(t_val);
        cmd.clear = 1'b1;
        state_d   = ST_STT;
      end
      ST_STT: begin
        k_d     = '0;
        state_d = ST_SMUL;
      end
      ST_SMUL: begin
        cmd.valid = 1'b1;
        case (k_q)
          2'd0:    cmd.x = prod_q[LIMB_W-1:0];
          2'd1:    cmd.x = prod_q[2*LIMB_W-1:LIMB_W];
          2'd2:    cmd.x = prod_q[3*LIMB_W-1:2*LIMB_W];
          default: cmd.x = '0;
        endcase
        cmd.y     = (k_q == 2'd0) ? LIMB_W'(wide[TT_W-1:0]) : LIMB_W'(tt_q);
        cmd.shift = k_q;
        cmd.clear = (k_q == 2'd0);
        if (k_q == 2'd0) tt_d = wide[TT_W-1:0];
        k_d       = k_q + 2'd1;
        if (k_q == 2'd2) state_d = ST_SWAIT;
      end
      ST_SWAIT: state_d = ST_SCMP;
      ST_SCMP: begin
        if (wide <= rhs_q) lo_d = mid_q;
        else               hi_d = mid_q - Q_W'(1);
        state_d = ST_STOP;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          cos_d       = res_q;
          zero_d      = rzero_q;
          clr_acc     = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    last_q  <= last_d;
    neg_q   <= neg_d;
    mag_q   <= mag_d;
    prod_q  <= prod_d;
    rhs_q   <= rhs_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    tt_q    <= tt_d;
    res_q   <= res_d;
    rzero_q <= rzero_d;
    cos_q   <= cos_d;
    zero_q  <= zero_d;
  end

  assign out_valid_o   = out_valid_q;
  assign cosine_o      = cos_q;
  assign zero_vector_o = zero_q;

endmodule
